// ===== hw/rtl/fcr_pkg.sv =====
`default_nettype none

package fcr_pkg;

   localparam logic [7:0] START_BYTE         = 8'h3A;
   localparam logic [7:0] BROADCAST_ADDR     = 8'hFF;
   localparam logic [7:0] HEADER_LEN         = 8'd5;
   localparam logic [7:0] NODE_ADDRESS_RESET = 8'd4;

   localparam logic EVENT_PAYLOAD   = 1'b0;
   localparam logic EVENT_FRAME_END = 1'b1;

   typedef struct packed {
      logic       event_kind;
      logic [7:0] function_code;
      logic [7:0] subfunction_code;
      logic [7:0] payload_index;
      logic [7:0] payload_byte;
      logic [7:0] payload_length;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fcr_parser.sv =====
`default_nettype none

module fcr_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 beat_valid,
   input  wire logic [7:0]           rx_byte,
   input  wire logic                 csr_wr_en,
   input  wire logic [7:0]           csr_wr_data,
   output logic                      res_valid,
   output fcr_pkg::rsp_item_type     res
);
   import fcr_pkg::*;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] address_ff, address_in;
   logic [7:0] function_ff, function_in;
   logic [7:0] subfunction_ff, subfunction_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] node_address_ff;

   always_comb begin
      logic       take_header;
      logic [7:0] hdr_cnt;
      logic [7:0] hdr_next;
      take_header    = 1'b0;
      hdr_cnt        = count_ff;
      hdr_next       = count_ff + 8'd1;
      phase_in       = phase_ff;
      count_in       = count_ff;
      address_in     = address_ff;
      function_in    = function_ff;
      subfunction_in = subfunction_ff;
      length_in      = length_ff;
      res_valid      = 1'b0;
      res.event_kind       = EVENT_PAYLOAD;
      res.function_code    = function_ff;
      res.subfunction_code = subfunction_ff;
      res.payload_index    = count_ff;
      res.payload_byte     = rx_byte;
      res.payload_length   = length_ff;

      if (beat_valid) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               res_valid = 1'b1;
               if (count_ff < length_ff) begin
                  count_in = count_ff + 8'd1;
               end else begin
                  res.event_kind    = EVENT_FRAME_END;
                  res.payload_index = 8'd0;
                  res.payload_byte  = 8'd0;
                  phase_in          = PH_IDLE;
                  count_in          = 8'd0;
               end
            end
            PH_HEADER: begin
               take_header = 1'b1;
            end
            default: begin
               // idle, and the unused code falls back to idle
               phase_in = PH_IDLE;
               if (rx_byte == START_BYTE) begin
                  take_header = 1'b1;
                  hdr_cnt     = 8'd0;
               end
            end
         endcase

         if (take_header) begin
            hdr_next = hdr_cnt + 8'd1;
            case (hdr_cnt)
               8'd1:    address_in     = rx_byte;
               8'd2:    function_in    = rx_byte;
               8'd3:    subfunction_in = rx_byte;
               8'd4:    length_in      = rx_byte;
               default: ;
            endcase
            if (hdr_next >= HEADER_LEN) begin
               // address byte came in on an earlier beat
               if (address_ff == node_address_ff || address_ff == BROADCAST_ADDR) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_IDLE;
               end
               count_in = 8'd0;
            end else begin
               phase_in = PH_HEADER;
               count_in = hdr_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         count_ff        <= 8'd0;
         address_ff      <= 8'd0;
         function_ff     <= 8'd0;
         subfunction_ff  <= 8'd0;
         length_ff       <= 8'd0;
         node_address_ff <= NODE_ADDRESS_RESET;
      end else begin
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         address_ff     <= address_in;
         function_ff    <= function_in;
         subfunction_ff <= subfunction_in;
         length_ff      <= length_in;
         if (csr_wr_en) begin
            node_address_ff <= csr_wr_data;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fcr_rsp_queue.sv =====
`default_nettype none

module fcr_rsp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire fcr_pkg::rsp_item_type push_item,
   output logic                      full,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output fcr_pkg::rsp_item_type     pop_item
);
   import fcr_pkg::*;

   rsp_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/framed_command_receiver_unit.sv =====
`default_nettype none
// a result beat is registered in the result queue and offered once the results ahead of it are taken
// throughput: one byte per cycle while the result queue is not full, set by the header/payload state machine
// a two-entry result queue keeps bytes flowing while a result waits to be taken
// synchronous active-high reset: receiver idle, header fields zero, node address 4,
// result queue empty

module framed_command_receiver_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // function_code, subfunction_code, payload_index,
                                         // payload_byte, payload_length
   output logic             rsp_tuser,   // event_kind
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);
   import fcr_pkg::*;

   logic         beat_valid;
   logic         res_valid;
   logic         queue_full;
   rsp_item_type res;
   rsp_item_type head;

   assign req_tready = !queue_full;
   assign beat_valid = req_tvalid && req_tready;

   fcr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (beat_valid),
      .rx_byte     (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .res_valid   (res_valid),
      .res         (res)
   );

   fcr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res),
      .full      (queue_full),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_item  (head)
   );

   assign rsp_tuser = head.event_kind;
   assign rsp_tdata = {head.payload_length, head.payload_byte, head.payload_index,
                       head.subfunction_code, head.function_code};

endmodule

`default_nettype wire

// ===== sim/framed_command_receiver_unit_test.sv =====
`timescale 1ns / 100ps

module framed_command_receiver_unit_test;
   import fcr_pkg::*;

   typedef enum logic [1:0] {
      RX_IDLE    = 2'd0,
      RX_HEADER  = 2'd1,
      RX_PAYLOAD = 2'd2
   } rx_phase_type;

   // positions of the header fields after the start byte
   localparam logic [7:0] HDR_ADDRESS     = 8'd1;
   localparam logic [7:0] HDR_FUNCTION    = 8'd2;
   localparam logic [7:0] HDR_SUBFUNCTION = 8'd3;
   localparam logic [7:0] HDR_LENGTH      = 8'd4;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;

   // receiver copy kept alongside the block
   rx_phase_type rx_phase = RX_IDLE;
   logic [7:0] rx_count = 8'h00;
   logic [7:0] hdr_address = 8'h00;
   logic [7:0] hdr_function = 8'h00;
   logic [7:0] hdr_subfunction = 8'h00;
   logic [7:0] hdr_length = 8'h00;
   logic [7:0] node_address = NODE_ADDRESS_RESET;

   logic [7:0]   rx_byte_q [$];
   rsp_item_type expected_events [$];
   int           mismatch_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;

   framed_command_receiver_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic advance_receiver(input logic [7:0] rx, output bit produced,
                                   output rsp_item_type ev);
      produced = 1'b0;
      ev = '0;
      if (rx_phase == RX_PAYLOAD) begin
         produced = 1'b1;
         ev.function_code    = hdr_function;
         ev.subfunction_code = hdr_subfunction;
         ev.payload_length   = hdr_length;
         if (rx_count < hdr_length) begin
            ev.event_kind    = EVENT_PAYLOAD;
            ev.payload_index = rx_count;
            ev.payload_byte  = rx;
            rx_count = rx_count + 8'd1;
         end else begin
            // closing byte, value ignored
            ev.event_kind = EVENT_FRAME_END;
            rx_phase = RX_IDLE;
            rx_count = 8'h00;
         end
      end else begin
         if (rx_phase != RX_HEADER) begin
            rx_phase = RX_IDLE;
            if (rx == START_BYTE) begin
               rx_phase = RX_HEADER;
               rx_count = 8'h00;
            end
         end
         if (rx_phase == RX_HEADER) begin
            case (rx_count)
               HDR_ADDRESS:     hdr_address = rx;
               HDR_FUNCTION:    hdr_function = rx;
               HDR_SUBFUNCTION: hdr_subfunction = rx;
               HDR_LENGTH:      hdr_length = rx;
               default: ;
            endcase
            rx_count = rx_count + 8'd1;
            if (rx_count >= HEADER_LEN) begin
               if (hdr_address == node_address || hdr_address == BROADCAST_ADDR)
                  rx_phase = RX_PAYLOAD;
               else
                  rx_phase = RX_IDLE;
               rx_count = 8'h00;
            end
         end
      end
   endtask

   // driver: feeds pending bytes, predicts on every accepted beat
   always @(posedge clock) begin : driver
      bit           produced;
      rsp_item_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
         rx_phase = RX_IDLE;
         rx_count = 8'h00;
         hdr_address = 8'h00;
         hdr_function = 8'h00;
         hdr_subfunction = 8'h00;
         hdr_length = 8'h00;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_receiver(req_tdata, produced, ev);
            if (produced)
               expected_events.push_back(ev);
         end
         if (!req_tvalid || req_tready) begin
            if (rx_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= rx_byte_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks every result beat against the oldest expected event
   always @(posedge clock) begin : monitor
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.event_kind       = rsp_tuser;
            got.function_code    = rsp_tdata[7:0];
            got.subfunction_code = rsp_tdata[15:8];
            got.payload_index    = rsp_tdata[23:16];
            got.payload_byte     = rsp_tdata[31:24];
            got.payload_length   = rsp_tdata[39:32];
            if (expected_events.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display({"unexpected result beat: ",
                            "kind=%0d func=%02h sub=%02h idx=%0d data=%02h len=%0d"},
                           got.event_kind, got.function_code, got.subfunction_code,
                           got.payload_index, got.payload_byte, got.payload_length);
            end else begin
               want = expected_events.pop_front();
               if (got.event_kind !== want.event_kind ||
                   got.function_code !== want.function_code ||
                   got.subfunction_code !== want.subfunction_code ||
                   got.payload_index !== want.payload_index ||
                   got.payload_byte !== want.payload_byte ||
                   got.payload_length !== want.payload_length) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected ",
                               "kind=%0d func=%02h sub=%02h idx=%0d data=%02h len=%0d, ",
                               "got kind=%0d func=%02h sub=%02h idx=%0d data=%02h len=%0d"},
                              want.event_kind, want.function_code, want.subfunction_code,
                              want.payload_index, want.payload_byte, want.payload_length,
                              got.event_kind, got.function_code, got.subfunction_code,
                              got.payload_index, got.payload_byte, got.payload_length);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic wait_stream_idle();
      while (rx_byte_q.size() != 0 || req_tvalid || expected_events.size() != 0)
         @(posedge clock);
      // bytes that give no result may still be in flight
      repeat (4) @(posedge clock);
   endtask

   task automatic write_node_address(input logic [7:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      node_address = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_frame(input logic [7:0] addr, input logic [7:0] len);
      rx_byte_q.push_back(START_BYTE);
      rx_byte_q.push_back(addr);
      rx_byte_q.push_back(8'($urandom_range(255)));
      rx_byte_q.push_back(8'($urandom_range(255)));
      rx_byte_q.push_back(len);
      for (int i = 0; i < len; i++)
         rx_byte_q.push_back(8'($urandom_range(255)));
      // closing byte, sometimes a start byte to show it is not taken as one
      rx_byte_q.push_back(($urandom_range(7) == 0) ? START_BYTE : 8'($urandom_range(255)));
   endtask

   task automatic queue_random_traffic(input int target);
      int         queued;
      int         burst;
      logic [7:0] addr;
      logic [7:0] len;
      queued = 0;
      while (queued < target) begin
         if ($urandom_range(9) < 8) begin
            case ($urandom_range(3))
               0, 1:    addr = node_address;
               2:       addr = BROADCAST_ADDR;
               default: addr = 8'($urandom_range(255));
            endcase
            len = ($urandom_range(39) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
            queue_frame(addr, len);
            queued = queued + 6 + len;
         end else begin
            // noise, stray start bytes break into partial headers
            burst = $urandom_range(1, 8);
            repeat (burst)
               rx_byte_q.push_back(($urandom_range(5) == 0) ? START_BYTE
                                                           : 8'($urandom_range(255)));
            queued = queued + burst;
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0] addr_plan [6];
      addr_plan[0] = 8'h00;
      addr_plan[1] = BROADCAST_ADDR;
      addr_plan[2] = START_BYTE;
      addr_plan[3] = 8'($urandom_range(255));
      addr_plan[4] = NODE_ADDRESS_RESET;
      addr_plan[5] = 8'($urandom_range(255));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct <= 19;
      recv_idle_pct <= 57;

      // noise, frame to the reset address, empty broadcast frame, foreign frame
      rx_byte_q = '{8'h00, 8'hFF,
                    START_BYTE, NODE_ADDRESS_RESET, 8'h00, 8'hFF, 8'd2, 8'hAA, 8'h55,
                    START_BYTE,
                    START_BYTE, BROADCAST_ADDR, 8'hFF, 8'h00, 8'd0, START_BYTE,
                    START_BYTE, 8'h05, 8'h11, 8'h22, START_BYTE, 8'h01};
      wait_stream_idle();

      for (int seg = 0; seg < 6; seg++) begin
         if (seg == 2) begin
            send_idle_pct <= 57;
            recv_idle_pct <= 19;
         end else if (seg == 4) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         write_node_address(addr_plan[seg]);
         queue_random_traffic(70);
         if (seg == 5)
            queue_frame(BROADCAST_ADDR, 8'd255);
         wait_stream_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("framed_command_receiver_unit_test: PASS");
      end else begin
         $display("framed_command_receiver_unit_test: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("framed_command_receiver_unit_test: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/fcr_pkg.sv
hw/rtl/fcr_parser.sv
hw/rtl/fcr_rsp_queue.sv
hw/rtl/framed_command_receiver_unit.sv
sim/framed_command_receiver_unit_test.sv
